// ===== sv/tbvs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbvs_pkg
// Shared constants and types of the two-bone vertex skinning pipeline.
// ----------------------------------------------------------------------------
package tbvs_pkg;

	// Fixed-point format of positions, matrix words and normals.
	localparam int FRAC_BITS = 16;

	// A bone matrix is 3 rows by 4 columns, stored row-major.
	localparam int WORDS = 12;
	localparam int SLOT_W = 4;
	localparam int BONE_W = 8;
	localparam int IDX_W = 13;

	// The weight is given in percent.
	localparam int WSCALE = 100;
	localparam int WEIGHT_W = 7;

	// Blended matrix element and rotated normal component widths.
	localparam int MW = 33;
	localparam int NV_W = 53;
	localparam int NRM_W = 18;
	localparam int NRM_MAX = 131071;
	localparam int NRM_MIN = -131072;

	// Input word kinds carried in tuser.
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_SKIN = 1'b1
	} op_t;

	typedef logic [WORDS-1:0][31:0] row_t;
	typedef logic signed [MW-1:0] mel_t;
	typedef logic signed [NV_W-1:0] nv_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec32_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
	} vec18_t;

	typedef struct packed {
		vec32_t pos;
		vec18_t nrm;
	} vtx_t;

	typedef struct packed {
		vec32_t pos;
		vec18_t nrm;
		logic   degen;
	} res_t;

endpackage

// ===== sv/tbvs_palette.sv =====
// ----------------------------------------------------------------------------
// tbvs_palette
// Matrix palette memory: one row of twelve words per bone, written one word
// at a time and read for two bones at once with registered read data.
// ----------------------------------------------------------------------------
module tbvs_palette #(
	parameter int MAX_BONES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  tbvs_pkg::op_t                       opcode,
	input  logic [tbvs_pkg::BONE_W-1:0]         bone_a,
	input  logic [tbvs_pkg::BONE_W-1:0]         bone_b,
	input  logic [tbvs_pkg::SLOT_W-1:0]         matrix_slot,
	input  logic [31:0]                         matrix_value,
	input  logic [tbvs_pkg::WEIGHT_W-1:0]       weight_percent,
	input  tbvs_pkg::vtx_t                      vtx_in,
	output logic                                v_s1,
	output tbvs_pkg::row_t                      row_a_s1,
	output tbvs_pkg::row_t                      row_b_s1,
	output logic                                ok_a_s1,
	output logic                                ok_b_s1,
	output logic [tbvs_pkg::WEIGHT_W-1:0]       w_s1,
	output tbvs_pkg::vtx_t                      vtx_s1
);

	localparam int AW = $clog2(MAX_BONES);

	tbvs_pkg::row_t palette_q [MAX_BONES];

	logic [tbvs_pkg::IDX_W-1:0] ext_a, ext_b;
	logic                       in_a, in_b, wr;

	// Bones past the palette are never written and count as zero in the blend.
	assign ext_a = tbvs_pkg::IDX_W'(bone_a);
	assign ext_b = tbvs_pkg::IDX_W'(bone_b);
	assign in_a  = ext_a < tbvs_pkg::IDX_W'(MAX_BONES);
	assign in_b  = ext_b < tbvs_pkg::IDX_W'(MAX_BONES);
	assign wr    = en && in_valid && (opcode == tbvs_pkg::OP_LOAD) && in_a &&
		(matrix_slot < tbvs_pkg::SLOT_W'(tbvs_pkg::WORDS));

	// Word write into the addressed row.
	always_ff @(posedge clk) begin
		if (wr) begin
			palette_q[ext_a[AW-1:0]][matrix_slot] <= matrix_value;
		end
	end

	// Two registered row reads, held while the pipeline is stalled.
	always_ff @(posedge clk) begin
		if (en) begin
			row_a_s1 <= palette_q[ext_a[AW-1:0]];
			row_b_s1 <= palette_q[ext_b[AW-1:0]];
			ok_a_s1  <= in_a;
			ok_b_s1  <= in_b;
			w_s1     <= weight_percent;
			vtx_s1   <= vtx_in;
		end
	end

	// Only vertex words continue down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && (opcode == tbvs_pkg::OP_SKIN);
		end
	end

endmodule

// ===== sv/tbvs_blend.sv =====
// ----------------------------------------------------------------------------
// tbvs_blend
// Blends the two bone matrices by percent weight and divides by one hundred
// with rounding, one byte of quotient per pipeline stage.
// ----------------------------------------------------------------------------
module tbvs_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  tbvs_pkg::row_t                row_a,
	input  tbvs_pkg::row_t                row_b,
	input  logic                          ok_a,
	input  logic                          ok_b,
	input  logic [tbvs_pkg::WEIGHT_W-1:0] weight,
	input  tbvs_pkg::vtx_t                vtx_in,
	output logic                          out_valid,
	output tbvs_pkg::mel_t                m_out [tbvs_pkg::WORDS],
	output tbvs_pkg::vtx_t                vtx_out
);

	localparam int WORDS = tbvs_pkg::WORDS;
	localparam int SUM_W = 41;
	localparam int X_W = 40;
	localparam int DIG_W = 8;
	localparam int REM_W = 7;
	localparam int DIGITS = X_W / DIG_W;
	localparam int V_W = REM_W + DIG_W;
	localparam int P_W = 28;
	localparam int RECIP = 5243;
	localparam int RSHIFT = 19;
	localparam int WW = tbvs_pkg::WEIGHT_W;

	// Divide a remainder and the next byte by one hundred: {quotient, remainder}.
	function automatic logic [V_W-1:0] digit_div(input logic [REM_W-1:0] r,
			input logic [DIG_W-1:0] d);
		logic [V_W-1:0]   v;
		logic [P_W-1:0]   p;
		logic [DIG_W-1:0] q;
		logic [V_W-1:0]   back;
		v = {r, d};
		p = P_W'(v) * P_W'(RECIP);
		q = p[RSHIFT +: DIG_W];
		back = V_W'(q) * V_W'(tbvs_pkg::WSCALE);
		return {q, REM_W'(v - back)};
	endfunction

	logic [WW-1:0]           wa, wb;
	logic signed [31:0]      elem_a [WORDS];
	logic signed [31:0]      elem_b [WORDS];
	logic signed [SUM_W-1:0] sum_nx [WORDS];
	logic signed [SUM_W-1:0] sum_s1 [WORDS];
	logic signed [SUM_W-1:0] abs_nx [WORDS];
	logic                    v_s1;
	tbvs_pkg::vtx_t          vtx_s1;

	logic [X_W-1:0]   x_q   [DIGITS+1][WORDS];
	logic [X_W-1:0]   quo_q [DIGITS+1][WORDS];
	logic [REM_W-1:0] rem_q [DIGITS+1][WORDS];
	logic             neg_q [DIGITS+1][WORDS];
	logic             v_q   [DIGITS+1];
	tbvs_pkg::vtx_t   vtx_q [DIGITS+1];
	logic [V_W-1:0]   dig   [DIGITS][WORDS];
	tbvs_pkg::mel_t   qm    [WORDS];

	// Weighted sum of the two matrices, weight clamped to one hundred.
	always_comb begin
		wa = (weight > WW'(tbvs_pkg::WSCALE)) ? WW'(tbvs_pkg::WSCALE) : weight;
		wb = WW'(tbvs_pkg::WSCALE) - wa;
		for (int c = 0; c < WORDS; c++) begin
			elem_a[c] = ok_a ? signed'(row_a[c]) : '0;
			elem_b[c] = ok_b ? signed'(row_b[c]) : '0;
			sum_nx[c] = elem_a[c] * signed'({1'b0, wa}) +
				elem_b[c] * signed'({1'b0, wb});
		end
	end

	// Magnitude, digit steps and final sign of each element.
	always_comb begin
		for (int c = 0; c < WORDS; c++) begin
			abs_nx[c] = sum_s1[c][SUM_W-1] ? -sum_s1[c] : sum_s1[c];
			qm[c] = tbvs_pkg::MW'(quo_q[DIGITS][c]);
			for (int k = 0; k < DIGITS; k++) begin
				dig[k][c] = digit_div(rem_q[k][c], x_q[k][c][X_W-1 -: DIG_W]);
			end
		end
	end

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_nx;
			vtx_s1 <= vtx_in;
			for (int c = 0; c < WORDS; c++) begin
				neg_q[0][c] <= sum_s1[c][SUM_W-1];
				x_q[0][c]   <= X_W'(unsigned'(abs_nx[c])) + X_W'(tbvs_pkg::WSCALE / 2);
				quo_q[0][c] <= '0;
				rem_q[0][c] <= '0;
				for (int k = 0; k < DIGITS; k++) begin
					neg_q[k+1][c] <= neg_q[k][c];
					x_q[k+1][c]   <= x_q[k][c] << DIG_W;
					quo_q[k+1][c] <= {quo_q[k][c][X_W-DIG_W-1:0], dig[k][c][V_W-1 -: DIG_W]};
					rem_q[k+1][c] <= dig[k][c][REM_W-1:0];
				end
				m_out[c] <= neg_q[DIGITS][c] ? -qm[c] : qm[c];
			end
			vtx_q[0] <= vtx_s1;
			for (int k = 0; k < DIGITS; k++) begin
				vtx_q[k+1] <= vtx_q[k];
			end
			vtx_out <= vtx_q[DIGITS];
		end
	end

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 0; k <= DIGITS; k++) begin
				v_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= in_valid;
			v_q[0] <= v_s1;
			for (int k = 0; k < DIGITS; k++) begin
				v_q[k+1] <= v_q[k];
			end
			out_valid <= v_q[DIGITS];
		end
	end

endmodule

// ===== sv/tbvs_xform.sv =====
// ----------------------------------------------------------------------------
// tbvs_xform
// Transforms the position by the blended 3x4 matrix with rounding and
// saturation, and rotates the normal by its 3x3 part.
// ----------------------------------------------------------------------------
module tbvs_xform (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tbvs_pkg::mel_t  m_in [tbvs_pkg::WORDS],
	input  tbvs_pkg::vtx_t  vtx_in,
	output logic            out_valid,
	output tbvs_pkg::vec32_t pos_out,
	output tbvs_pkg::nv_t   nv_out [3]
);

	localparam int F = tbvs_pkg::FRAC_BITS;
	localparam int PP_W = tbvs_pkg::MW + 32;
	localparam int NP_W = tbvs_pkg::MW + tbvs_pkg::NRM_W;
	localparam int PS_W = PP_W + 2;
	localparam int ACC_W = PS_W + 1;
	localparam logic signed [ACC_W-1:0] PMAX = ACC_W'(32'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] PMIN = ACC_W'(signed'(32'h8000_0000));

	logic signed [31:0]             p [3];
	logic signed [tbvs_pkg::NRM_W-1:0] n [3];
	logic signed [PP_W-1:0]  pp_x1 [3][3];
	logic signed [NP_W-1:0]  np_x1 [3][3];
	tbvs_pkg::mel_t          t_x1 [3];
	tbvs_pkg::mel_t          t_x2 [3];
	logic signed [PS_W-1:0]  ps_x2 [3];
	tbvs_pkg::nv_t           nv_x2 [3];
	logic signed [ACC_W-1:0] acc [3];
	logic signed [ACC_W-1:0] sh [3];
	logic signed [31:0]      sat [3];
	logic                    v_x1, v_x2;

	// Input vectors as arrays.
	always_comb begin
		p[0] = vtx_in.pos.x;
		p[1] = vtx_in.pos.y;
		p[2] = vtx_in.pos.z;
		n[0] = vtx_in.nrm.x;
		n[1] = vtx_in.nrm.y;
		n[2] = vtx_in.nrm.z;
	end

	// Rounded translation add and saturation of the position.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = ACC_W'(ps_x2[r]) + (ACC_W'(t_x2[r]) <<< F) +
				(ACC_W'(1) << (F - 1));
			sh[r] = acc[r] >>> F;
			if (sh[r] > PMAX) begin
				sat[r] = 32'sh7FFF_FFFF;
			end else if (sh[r] < PMIN) begin
				sat[r] = signed'(32'h8000_0000);
			end else begin
				sat[r] = sh[r][31:0];
			end
		end
	end

	// Products, row sums and the output stage.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pp_x1[r][c] <= m_in[r*4+c] * p[c];
					np_x1[r][c] <= m_in[r*4+c] * n[c];
				end
				t_x1[r]  <= m_in[r*4+3];
				t_x2[r]  <= t_x1[r];
				ps_x2[r] <= PS_W'(pp_x1[r][0]) + PS_W'(pp_x1[r][1]) + PS_W'(pp_x1[r][2]);
				nv_x2[r] <= tbvs_pkg::NV_W'(np_x1[r][0]) + tbvs_pkg::NV_W'(np_x1[r][1]) +
					tbvs_pkg::NV_W'(np_x1[r][2]);
				nv_out[r] <= nv_x2[r];
			end
			pos_out.x <= sat[0];
			pos_out.y <= sat[1];
			pos_out.z <= sat[2];
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_x1      <= 1'b0;
			v_x2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_x1      <= in_valid;
			v_x2      <= v_x1;
			out_valid <= v_x2;
		end
	end

endmodule

// ===== sv/tbvs_nrm.sv =====
// ----------------------------------------------------------------------------
// tbvs_nrm
// Normal renormalization: scales the rotated normal into a fixed range,
// takes the integer square root of its squared length bit by bit, and
// divides each component by the length one quotient bit per stage.
// ----------------------------------------------------------------------------
module tbvs_nrm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  tbvs_pkg::nv_t    nv_in [3],
	input  tbvs_pkg::vec32_t pos_in,
	output logic             out_valid,
	output tbvs_pkg::res_t   res_out
);

	localparam int F = tbvs_pkg::FRAC_BITS;
	localparam int MAG_W = tbvs_pkg::NV_W;
	localparam int NG = (MAG_W + 7) / 8;
	localparam int OR_W = NG * 8;
	localparam int MSB_W = $clog2(OR_W);
	localparam int GI_W = 3;
	localparam int UNIT_W = 30;
	localparam int TOP = UNIT_W - 1;
	localparam int SQ_W = 2 * UNIT_W;
	localparam int IS_W = SQ_W + 4;
	localparam int ROOT_W = UNIT_W + 1;
	localparam int DV_W = ROOT_W + F + 1;
	localparam int Q_W = F + 1;
	localparam int OV_W = (Q_W + 2 > tbvs_pkg::NRM_W + 1) ? Q_W + 2 : tbvs_pkg::NRM_W + 1;

	typedef struct packed {
		tbvs_pkg::vec32_t pos;
		logic             zero;
		logic [2:0]       sgn;
	} car_t;

	// Front stages.
	logic [MAG_W-1:0]  mag_n1 [3];
	logic [MAG_W-1:0]  mag_n2 [3];
	logic [MAG_W-1:0]  mag_n3 [3];
	logic [NG-1:0]     gnz_nx, gnz_n2;
	logic [GI_W-1:0]   gpos_nx [NG];
	logic [GI_W-1:0]   gpos_n2 [NG];
	logic [OR_W-1:0]   orv;
	logic [MSB_W-1:0]  msb_nx, msb_n3;
	logic [UNIT_W-1:0] unit_nx [3];
	logic [UNIT_W-1:0] unit_n4 [3];
	logic [UNIT_W-1:0] unit_n5 [3];
	logic [SQ_W-1:0]   sq_n5 [3];
	car_t              car_nx, car_n1, car_n2, car_n3, car_n4, car_n5;
	logic              v_n1, v_n2, v_n3, v_n4, v_n5;

	// Square root stages.
	logic [IS_W-1:0]   rx_q [ROOT_W+1];
	logic [ROOT_W-1:0] rr_q [ROOT_W+1];
	logic [UNIT_W-1:0] ru_q [ROOT_W+1][3];
	car_t              rc_q [ROOT_W+1];
	logic              rv_q [ROOT_W+1];
	logic [IS_W-1:0]   rt   [ROOT_W];

	// Divider stages.
	logic [DV_W-1:0]   dn_q [Q_W+1][3];
	logic [Q_W-1:0]    dq_q [Q_W+1][3];
	logic [ROOT_W-1:0] dl_q [Q_W+1];
	car_t              dc_q [Q_W+1];
	logic              dv_q [Q_W+1];
	logic [DV_W-1:0]   dsh  [Q_W];

	logic signed [OV_W-1:0]           qv [3];
	logic signed [tbvs_pkg::NRM_W-1:0] nout [3];

	// Signs of the rotated normal.
	always_comb begin
		car_nx.pos = pos_in;
		car_nx.zero = 1'b0;
		for (int c = 0; c < 3; c++) begin
			car_nx.sgn[c] = nv_in[c][MAG_W-1];
		end
	end

	// Leading one of the largest magnitude, found per byte and then overall.
	always_comb begin
		orv = OR_W'(mag_n1[0] | mag_n1[1] | mag_n1[2]);
		for (int g = 0; g < NG; g++) begin
			gnz_nx[g]  = |orv[g*8 +: 8];
			gpos_nx[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (orv[g*8+b]) begin
					gpos_nx[g] = GI_W'(b);
				end
			end
		end
		msb_nx = '0;
		for (int g = 0; g < NG; g++) begin
			if (gnz_n2[g]) begin
				msb_nx = MSB_W'(g * 8) + MSB_W'(gpos_n2[g]);
			end
		end
	end

	// Common shift that puts the largest magnitude just below two to the 30.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (msb_n3 >= MSB_W'(TOP)) begin
				unit_nx[c] = UNIT_W'(mag_n3[c] >> (msb_n3 - MSB_W'(TOP)));
			end else begin
				unit_nx[c] = UNIT_W'(mag_n3[c] << (MSB_W'(TOP) - msb_n3));
			end
		end
	end

	// Trial values of the square root and shifted divisors.
	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			rt[k] = (IS_W'(rr_q[k]) << (ROOT_W - k)) + (IS_W'(1) << (2 * (ROOT_W - 1 - k)));
		end
		for (int j = 0; j < Q_W; j++) begin
			dsh[j] = DV_W'(dl_q[j]) << (Q_W - 1 - j);
		end
	end

	// Sign restore and saturation of the unit normal.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qv[c] = dc_q[Q_W].sgn[c] ? -OV_W'(dq_q[Q_W][c]) : OV_W'(dq_q[Q_W][c]);
			if (qv[c] > OV_W'(tbvs_pkg::NRM_MAX)) begin
				nout[c] = tbvs_pkg::NRM_W'(tbvs_pkg::NRM_MAX);
			end else if (qv[c] < OV_W'(tbvs_pkg::NRM_MIN)) begin
				nout[c] = tbvs_pkg::NRM_W'(tbvs_pkg::NRM_MIN);
			end else begin
				nout[c] = qv[c][tbvs_pkg::NRM_W-1:0];
			end
		end
	end

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mag_n1[c]  <= nv_in[c][MAG_W-1] ? MAG_W'(-nv_in[c]) : MAG_W'(nv_in[c]);
				mag_n2[c]  <= mag_n1[c];
				mag_n3[c]  <= mag_n2[c];
				unit_n4[c] <= unit_nx[c];
				unit_n5[c] <= unit_n4[c];
				sq_n5[c]   <= SQ_W'(unit_n4[c]) * SQ_W'(unit_n4[c]);
				ru_q[0][c] <= unit_n5[c];
			end
			car_n1 <= car_nx;
			car_n2 <= car_n1;
			// The zero flag joins the carried word once the byte flags are known.
			car_n3 <= {car_n2.pos, ~|gnz_n2, car_n2.sgn};
			car_n4 <= car_n3;
			car_n5 <= car_n4;
			gnz_n2  <= gnz_nx;
			gpos_n2 <= gpos_nx;
			msb_n3  <= msb_nx;

			// Square root, one result bit per stage.
			rx_q[0] <= IS_W'(sq_n5[0]) + IS_W'(sq_n5[1]) + IS_W'(sq_n5[2]);
			rr_q[0] <= '0;
			rc_q[0] <= car_n5;
			for (int k = 0; k < ROOT_W; k++) begin
				if (rx_q[k] >= rt[k]) begin
					rx_q[k+1] <= rx_q[k] - rt[k];
					rr_q[k+1] <= rr_q[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
				end else begin
					rx_q[k+1] <= rx_q[k];
					rr_q[k+1] <= rr_q[k];
				end
				ru_q[k+1] <= ru_q[k];
				rc_q[k+1] <= rc_q[k];
			end

			// Rounded division by the length, one quotient bit per stage.
			for (int c = 0; c < 3; c++) begin
				dn_q[0][c] <= (DV_W'(ru_q[ROOT_W][c]) << F) + DV_W'(rr_q[ROOT_W] >> 1);
				dq_q[0][c] <= '0;
				for (int j = 0; j < Q_W; j++) begin
					if (dn_q[j][c] >= dsh[j]) begin
						dn_q[j+1][c] <= dn_q[j][c] - dsh[j];
						dq_q[j+1][c] <= dq_q[j][c] | (Q_W'(1) << (Q_W - 1 - j));
					end else begin
						dn_q[j+1][c] <= dn_q[j][c];
						dq_q[j+1][c] <= dq_q[j][c];
					end
				end
			end
			dl_q[0] <= rr_q[ROOT_W];
			dc_q[0] <= rc_q[ROOT_W];
			for (int j = 0; j < Q_W; j++) begin
				dl_q[j+1] <= dl_q[j];
				dc_q[j+1] <= dc_q[j];
			end

			// Result word; a zero normal gives zeros and the flag.
			res_out.pos   <= dc_q[Q_W].pos;
			res_out.degen <= dc_q[Q_W].zero;
			res_out.nrm.x <= dc_q[Q_W].zero ? '0 : nout[0];
			res_out.nrm.y <= dc_q[Q_W].zero ? '0 : nout[1];
			res_out.nrm.z <= dc_q[Q_W].zero ? '0 : nout[2];
		end
	end

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n1 <= 1'b0;
			v_n2 <= 1'b0;
			v_n3 <= 1'b0;
			v_n4 <= 1'b0;
			v_n5 <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++) begin
				rv_q[k] <= 1'b0;
			end
			for (int j = 0; j <= Q_W; j++) begin
				dv_q[j] <= 1'b0;
			end
		end else if (en) begin
			v_n1 <= in_valid;
			v_n2 <= v_n1;
			v_n3 <= v_n2;
			v_n4 <= v_n3;
			v_n5 <= v_n4;
			rv_q[0] <= v_n5;
			for (int k = 0; k < ROOT_W; k++) begin
				rv_q[k+1] <= rv_q[k];
			end
			dv_q[0] <= rv_q[ROOT_W];
			for (int j = 0; j < Q_W; j++) begin
				dv_q[j+1] <= dv_q[j];
			end
			out_valid <= dv_q[Q_W];
		end
	end

endmodule

// ===== sv/two_bone_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// two_bone_vertex_skinning
// Two-bone linear blend skinning of Q16.16 positions and Q2.16 normals.
//
// Input stream (s_*): tuser selects the word kind. A load word writes one
// word of a bone's 3x4 matrix into the palette and gives no result; a skin
// word carries a vertex, two bone indices and a percent weight.
// Output stream (m_*): one result word per skin word, in input order, with
// the skinned position, the unit skinned normal and a zero-normal flag.
// Most of the pipeline is the bit-per-stage square root (31 stages) and the
// normal divider (17 stages). Throughput is one word per cycle of either kind
// while s_tready is high.
// A skin word accepted right after a load word already sees the new value.
// Reset clears the pipeline valid bits; palette words are undefined until
// written. When the receiver stalls, one more result goes into a skid
// register and then the whole pipeline holds, with s_tready low, until the
// skid register drains.
// ----------------------------------------------------------------------------
module two_bone_vertex_skinning #(
	parameter int MAX_BONES = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// bone_a, bone_b, matrix_slot, matrix_value, pos_x, pos_y, pos_z,
	// nrm_x, nrm_y, nrm_z, weight_percent, zero fill
	input  logic [215:0] s_tdata,
	// opcode
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z, out_nx, out_ny, out_nz, zero fill
	output logic [151:0] m_tdata,
	// degenerate_normal
	output logic         m_tuser
);

	logic                       en;
	tbvs_pkg::op_t              opcode;
	tbvs_pkg::vtx_t             vtx_in;

	logic                       v_s1, ok_a_s1, ok_b_s1;
	tbvs_pkg::row_t             row_a_s1, row_b_s1;
	logic [tbvs_pkg::WEIGHT_W-1:0] w_s1;
	tbvs_pkg::vtx_t             vtx_s1;

	logic                       v_bl;
	tbvs_pkg::mel_t             m_bl [tbvs_pkg::WORDS];
	tbvs_pkg::vtx_t             vtx_bl;

	logic                       v_xf;
	tbvs_pkg::vec32_t           pos_xf;
	tbvs_pkg::nv_t              nv_xf [3];

	logic                       v_nr;
	tbvs_pkg::res_t             res_nr;

	logic                       out_v_q, skid_v_q;
	tbvs_pkg::res_t             out_q, skid_q;

	// The pipeline moves while the skid register is empty.
	assign en       = !skid_v_q;
	assign s_tready = en;
	assign opcode   = tbvs_pkg::op_t'(s_tuser);

	assign vtx_in.pos.x = s_tdata[83:52];
	assign vtx_in.pos.y = s_tdata[115:84];
	assign vtx_in.pos.z = s_tdata[147:116];
	assign vtx_in.nrm.x = s_tdata[165:148];
	assign vtx_in.nrm.y = s_tdata[183:166];
	assign vtx_in.nrm.z = s_tdata[201:184];

	tbvs_palette #(
		.MAX_BONES(MAX_BONES)
	) u_palette (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid),
		.opcode        (opcode),
		.bone_a        (s_tdata[7:0]),
		.bone_b        (s_tdata[15:8]),
		.matrix_slot   (s_tdata[19:16]),
		.matrix_value  (s_tdata[51:20]),
		.weight_percent(s_tdata[208:202]),
		.vtx_in        (vtx_in),
		.v_s1          (v_s1),
		.row_a_s1      (row_a_s1),
		.row_b_s1      (row_b_s1),
		.ok_a_s1       (ok_a_s1),
		.ok_b_s1       (ok_b_s1),
		.w_s1          (w_s1),
		.vtx_s1        (vtx_s1)
	);

	tbvs_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.row_a    (row_a_s1),
		.row_b    (row_b_s1),
		.ok_a     (ok_a_s1),
		.ok_b     (ok_b_s1),
		.weight   (w_s1),
		.vtx_in   (vtx_s1),
		.out_valid(v_bl),
		.m_out    (m_bl),
		.vtx_out  (vtx_bl)
	);

	tbvs_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_bl),
		.m_in     (m_bl),
		.vtx_in   (vtx_bl),
		.out_valid(v_xf),
		.pos_out  (pos_xf),
		.nv_out   (nv_xf)
	);

	tbvs_nrm u_nrm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_xf),
		.nv_in    (nv_xf),
		.pos_in   (pos_xf),
		.out_valid(v_nr),
		.res_out  (res_nr)
	);

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_nr;
			end
		end else if (v_nr && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : res_nr;
		end else if (v_nr && en) begin
			skid_q <= res_nr;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.degen;
	assign m_tdata  = {2'b00, out_q.nrm.z, out_q.nrm.y, out_q.nrm.x,
		out_q.pos.z, out_q.pos.y, out_q.pos.x};

endmodule

// ===== tb/two_bone_vertex_skinning_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_bone_vertex_skinning_test
// Self-checking bench for the two-bone skinning pipeline. Palette loads and
// vertices stream in with random gaps, results are drained with random
// stalls, and every result word is compared against a fixed-point predictor.
// ----------------------------------------------------------------------------
module two_bone_vertex_skinning_test;

	// Predicts skinned vertices from its own copy of the bone palette.
	class skin_scoreboard;
		bit [31:0]        palette [256*tbvs_pkg::WORDS];
		tbvs_pkg::res_t   pending_q [$];
		int               errors;

		function longint unsigned root_floor(longint unsigned x);
			longint unsigned r, bitv;
			r = 0;
			bitv = 64'd1 << 62;
			while (bitv > x)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (x >= r + bitv) begin
					x = x - (r + bitv);
					r = (r >> 1) + bitv;
				end else begin
					r = r >> 1;
				end
				bitv = bitv >> 2;
			end
			return r;
		endfunction

		function longint round_pct(longint s);
			if (s >= 0)
				return (s + tbvs_pkg::WSCALE / 2) / tbvs_pkg::WSCALE;
			return -((-s + tbvs_pkg::WSCALE / 2) / tbvs_pkg::WSCALE);
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// Called for every accepted input word.
		function void note_input(tbvs_pkg::op_t op, logic [215:0] d);
			int unsigned bone_a, bone_b, slot, wt;
			longint blend [tbvs_pkg::WORDS];
			longint pos [3], nrm [3], rot [3];
			longint unsigned mag [3], peak, sumsq, len, q;
			longint hi, lo, prod, v, wa, wb;
			int sh;
			tbvs_pkg::res_t e;
			bone_a = d[7:0];
			bone_b = d[15:8];
			slot = d[19:16];
			wt = d[208:202];
			if (op == tbvs_pkg::OP_LOAD) begin
				if (slot < tbvs_pkg::WORDS)
					palette[bone_a*tbvs_pkg::WORDS + slot] = d[51:20];
				return;
			end
			if (wt > tbvs_pkg::WSCALE)
				wt = tbvs_pkg::WSCALE;
			for (int c = 0; c < tbvs_pkg::WORDS; c++) begin
				wa = $signed(palette[bone_a*tbvs_pkg::WORDS + c]);
				wb = $signed(palette[bone_b*tbvs_pkg::WORDS + c]);
				blend[c] = round_pct(wa * wt + wb * (tbvs_pkg::WSCALE - wt));
			end
			pos[0] = $signed(d[83:52]);
			pos[1] = $signed(d[115:84]);
			pos[2] = $signed(d[147:116]);
			nrm[0] = $signed(d[165:148]);
			nrm[1] = $signed(d[183:166]);
			nrm[2] = $signed(d[201:184]);
			for (int r = 0; r < 3; r++) begin
				hi = blend[r*4 + 3];
				lo = 0;
				for (int c = 0; c < 3; c++) begin
					prod = blend[r*4 + c] * pos[c];
					hi += prod >>> tbvs_pkg::FRAC_BITS;
					lo += prod & ((64'd1 << tbvs_pkg::FRAC_BITS) - 1);
				end
				v = clamp(hi + ((lo + (64'd1 << (tbvs_pkg::FRAC_BITS - 1))) >>>
					tbvs_pkg::FRAC_BITS), -64'sd2147483648, 64'sd2147483647);
				if (r == 0) e.pos.x = v[31:0];
				else if (r == 1) e.pos.y = v[31:0];
				else e.pos.z = v[31:0];
				rot[r] = blend[r*4] * nrm[0] + blend[r*4 + 1] * nrm[1]
					+ blend[r*4 + 2] * nrm[2];
			end
			peak = 0;
			for (int c = 0; c < 3; c++) begin
				mag[c] = rot[c] < 0 ? -rot[c] : rot[c];
				if (mag[c] > peak)
					peak = mag[c];
			end
			e.degen = (peak == 0);
			e.nrm = '0;
			if (peak != 0) begin
				sh = 0;
				while (peak >= (64'd1 << 30)) begin
					peak = peak >> 1;
					sh--;
				end
				while (peak < (64'd1 << 29)) begin
					peak = peak << 1;
					sh++;
				end
				sumsq = 0;
				for (int c = 0; c < 3; c++) begin
					mag[c] = sh < 0 ? mag[c] >> (-sh) : mag[c] << sh;
					sumsq += mag[c] * mag[c];
				end
				len = root_floor(sumsq);
				for (int c = 0; c < 3; c++) begin
					q = ((mag[c] << tbvs_pkg::FRAC_BITS) + len / 2) / len;
					v = rot[c] < 0 ? -longint'(q) : longint'(q);
					v = clamp(v, tbvs_pkg::NRM_MIN, tbvs_pkg::NRM_MAX);
					if (c == 0) e.nrm.x = v[tbvs_pkg::NRM_W-1:0];
					else if (c == 1) e.nrm.y = v[tbvs_pkg::NRM_W-1:0];
					else e.nrm.z = v[tbvs_pkg::NRM_W-1:0];
				end
			end
			pending_q = {pending_q, e};
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		endtask

		// Called for every accepted result word.
		task check(logic [151:0] d, logic degen);
			tbvs_pkg::res_t e;
			if (pending_q.size() == 0) begin
				report("unexpected result word", 1, 0);
				return;
			end
			e = pending_q.pop_front();
			if ($signed(d[31:0]) != e.pos.x) report("out_x", $signed(d[31:0]), e.pos.x);
			if ($signed(d[63:32]) != e.pos.y) report("out_y", $signed(d[63:32]), e.pos.y);
			if ($signed(d[95:64]) != e.pos.z) report("out_z", $signed(d[95:64]), e.pos.z);
			if ($signed(d[113:96]) != e.nrm.x)
				report("out_nx", $signed(d[113:96]), e.nrm.x);
			if ($signed(d[131:114]) != e.nrm.y)
				report("out_ny", $signed(d[131:114]), e.nrm.y);
			if ($signed(d[149:132]) != e.nrm.z)
				report("out_nz", $signed(d[149:132]), e.nrm.z);
			if (degen != e.degen) report("degenerate_normal", degen, e.degen);
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [215:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [151:0] m_tdata;
	logic         m_tuser;

	skin_scoreboard sb;
	bit [11:0] loaded [256];
	bit calm;

	two_bone_vertex_skinning DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls about 22 percent of the time outside the calm stretch.
	always @(negedge clk) begin
		m_tready = calm ? 1'b1 : ($urandom_range(99) >= 22);
	end

	// Result words are checked at the edge that accepts them.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata, m_tuser);
	end

	function logic [215:0] load_word(bit [7:0] bone, bit [3:0] slot, bit [31:0] val);
		logic [215:0] d;
		d = '0;
		d[7:0] = bone;
		d[19:16] = slot;
		d[51:20] = val;
		return d;
	endfunction

	function logic [215:0] skin_word(bit [7:0] a, bit [7:0] b, bit [31:0] px,
			bit [31:0] py, bit [31:0] pz, bit [17:0] nx, bit [17:0] ny,
			bit [17:0] nz, bit [6:0] wt);
		logic [215:0] d;
		d = '0;
		d[7:0] = a;
		d[15:8] = b;
		d[83:52] = px;
		d[115:84] = py;
		d[147:116] = pz;
		d[165:148] = nx;
		d[183:166] = ny;
		d[201:184] = nz;
		d[208:202] = wt;
		return d;
	endfunction

	// Presents one word from a falling edge and holds it until accepted.
	task send(tbvs_pkg::op_t op, logic [215:0] d);
		if (!calm && $urandom_range(99) < 22) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_tuser = op;
		s_tdata = d;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, d);
		if (op == tbvs_pkg::OP_LOAD && d[19:16] < tbvs_pkg::WORDS)
			loaded[d[7:0]][d[19:16]] = 1'b1;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task load_bone(bit [7:0] bone, bit identity, bit [31:0] scale);
		for (int s = 0; s < tbvs_pkg::WORDS; s++) begin
			if (identity)
				send(tbvs_pkg::OP_LOAD, load_word(bone, 4'(s),
					(s % 5 == 0) ? scale : 32'd0));
			else
				send(tbvs_pkg::OP_LOAD, load_word(bone, 4'(s), $urandom));
		end
	endtask

	function bit [7:0] ready_bone();
		bit [7:0] b;
		for (int t = 0; t < 20; t++) begin
			b = 8'($urandom_range(255));
			if (loaded[b] == 12'hFFF)
				return b;
		end
		return 8'd0;
	endfunction

	function bit [31:0] rnd_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h3_0000) - 32'h1_8000;
			2: return $urandom_range(32'h200) - 32'h100;
			default: return $urandom_range(1) ? 32'h1_0000 : 32'hFFFF_0000;
		endcase
	endfunction

	function bit [17:0] rnd_normal();
		int v;
		v = $urandom_range(131072) - 65536;
		return v[17:0];
	endfunction

	initial begin
		sb = new();
		calm = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = tbvs_pkg::OP_LOAD;
		s_tdata = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Palette setup: identity, all-zero, extreme and random bones.
		load_bone(8'd0, 1'b1, 32'h0001_0000);
		load_bone(8'd1, 1'b1, 32'd0);
		load_bone(8'd255, 1'b1, 32'h7FFF_FFFF);
		load_bone(8'd128, 1'b1, 32'h8000_0000);
		load_bone(8'd7, 1'b0, 32'd0);
		// A slot above eleven is ignored.
		send(tbvs_pkg::OP_LOAD, load_word(8'd0, 4'd15, 32'hDEAD_BEEF));
		send(tbvs_pkg::OP_LOAD, load_word(8'd0, 4'd12, 32'h1234_5678));

		// Directed vertices: field extremes, zero normal, zero matrix, saturation.
		send(tbvs_pkg::OP_SKIN, skin_word(0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'd0,
			18'h10000, 18'd0, 18'd0, 7'd100));
		send(tbvs_pkg::OP_SKIN, skin_word(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			18'h30000, 18'h10000, 18'h30000, 7'd0));
		send(tbvs_pkg::OP_SKIN, skin_word(0, 7, 32'h1234, 32'h5678, 32'h9ABC,
			18'd0, 18'd0, 18'd0, 7'd50));
		send(tbvs_pkg::OP_SKIN, skin_word(1, 1, 32'h0100_0000, 32'd5, 32'd7,
			18'h10000, 18'h10000, 18'h10000, 7'd100));
		send(tbvs_pkg::OP_SKIN, skin_word(255, 255, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 18'h10000, 18'h10000, 18'h10000, 7'd100));
		send(tbvs_pkg::OP_SKIN, skin_word(128, 128, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 18'h30000, 18'h00001, 18'h3FFFF, 7'd0));
		send(tbvs_pkg::OP_SKIN, skin_word(255, 128, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 18'h1, 18'h3FFFF, 18'h10000, 7'd50));
		send(tbvs_pkg::OP_SKIN, skin_word(0, 255, 32'd1, 32'hFFFF_FFFF, 32'h8000,
			18'h3FFFF, 18'h0, 18'h0, 7'd127));
		send(tbvs_pkg::OP_SKIN, skin_word(7, 0, 32'hFFFF_8000, 32'h8000, 32'h0,
			18'h0, 18'h1, 18'h0, 7'd101));
		send(tbvs_pkg::OP_SKIN, skin_word(1, 0, 32'h4000_0000, 32'hC000_0000, 32'h1,
			18'h0ABCD, 18'h35432, 18'h01234, 7'd1));
		send(tbvs_pkg::OP_SKIN, skin_word(7, 7, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h5555_AAAA,
			18'h2AAAA, 18'h15555, 18'h0FFFF, 7'd99));

		// Random traffic: mostly vertices over loaded bones, some palette rewrites.
		for (int i = 0; i < 1500; i++) begin
			calm = (i >= 400 && i < 650);
			if (i == 800) begin
				// Hold the input until every expected result has been drained.
				while (sb.pending_q.size() != 0)
					@(negedge clk);
			end
			if ($urandom_range(99) < 25) begin
				if ($urandom_range(9) == 0)
					send(tbvs_pkg::OP_LOAD, load_word(8'($urandom_range(255)),
						4'($urandom_range(15)), rnd_value()));
				else
					send(tbvs_pkg::OP_LOAD, load_word($urandom_range(7) == 0 ?
						8'($urandom_range(255)) : ready_bone(),
						4'($urandom_range(11)), rnd_value()));
			end else begin
				send(tbvs_pkg::OP_SKIN, skin_word(ready_bone(), ready_bone(),
					$urandom_range(1) ? $urandom : rnd_value(),
					$urandom_range(1) ? $urandom : rnd_value(),
					$urandom_range(1) ? $urandom : rnd_value(),
					rnd_normal(), rnd_normal(),
					$urandom_range(19) == 0 ? 18'd0 : rnd_normal(),
					$urandom_range(9) == 0 ? 7'($urandom_range(127)) :
					7'($urandom_range(100))));
			end
		end
		calm = 1'b0;

		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
